/* src/fdec_pkg.sv */
// Shared constants and types for the float to decimal text converter.
package fdec_pkg;

    // Default limits on the produced text.
    localparam int BUFFER_BYTES_DEF    = 15;
    localparam int MAX_FRAC_DIGITS_DEF = 7;

    // The integer part stays below 2^31, which needs ten decimal digits.
    localparam int INT_DIGITS = 10;
    localparam int NDIG_W     = 4;
    localparam int CNT_W      = 5;

    // Significand with the hidden bit, and the fraction register width.
    localparam int MANT_W = 24;

    // Biased exponent landmarks.
    localparam logic [7:0] EXP_HALF     = 8'd126;  // value in [0.5, 1)
    localparam logic [7:0] EXP_BIAS     = 8'd127;  // value in [1, 2)
    localparam logic [7:0] EXP_RANGE    = 8'd158;  // 2^31 and above
    localparam logic [7:0] EXP_FRAC_MIN = 8'd103;  // smallest with fraction bits left

    // Character codes.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Commands to the serial BCD register.
    typedef struct packed {
        logic clear;
        logic shift_bit;
        logic din;
        logic shift_digit;
    } t_bcd_ctl;

endpackage

/* src/fdec_bcd.sv */
// Serial binary to BCD register (shift-add-3) with digit-wise readout.
module fdec_bcd (
    input  logic                 i_clk,
    input  fdec_pkg::t_bcd_ctl   i_ctl,
    output logic [3:0]           o_top_digit
);
    import fdec_pkg::*;

    localparam int BW = 4 * INT_DIGITS;

    logic [BW-1:0] r_bcd;
    logic [BW-1:0] n_bcd;
    logic [BW-1:0] w_adj;

    // Each digit of five or more gets three added before the doubling.
    always_comb begin
        for (int i = 0; i < INT_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_bcd = r_bcd;
        if (i_ctl.clear) begin
            n_bcd = '0;
        end else if (i_ctl.shift_bit) begin
            n_bcd = {w_adj[BW-2:0], i_ctl.din};
        end else if (i_ctl.shift_digit) begin
            n_bcd = {r_bcd[BW-5:0], 4'b0000};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[BW-1 -: 4];

endmodule

/* src/float_to_decimal_ascii.sv */
// Top level: single-precision bit pattern in, decimal text out one character a cycle.
//
// Pulse start while busy is low to hand over one 32-bit word. The text comes
// back on o_out_char with o_valid high for one cycle per character and
// o_last_char on the final one; the receiver cannot hold characters off, so
// it must take one every cycle. A word whose magnitude is 2^31 or more, infinity
// or NaN gives a single word with o_range_error and o_last_char set, in the
// cycle after start, and the block stays ready. Otherwise a conversion shifts
// the integer bits (up to 31) into the BCD register or, for values below one,
// right-aligns the significand. It then drops leading zero digits from the
// 10-digit BCD register, forms MAX_FRAC_DIGITS digits in the times-ten fraction
// digit unit, and sends the characters. Each character shows in the cycle after
// its state. The BCD conversion is bit-serial, and the fraction unit makes one
// digit a cycle.
// The next word may be started in the cycle that shows the last character.
module float_to_decimal_ascii #(
    parameter int BUFFER_BYTES    = fdec_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_FRAC_DIGITS = fdec_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [31:0] i_float_bits,
    output logic        busy,
    output logic        o_valid,
    output logic [7:0]  o_out_char,
    output logic        o_last_char,
    output logic        o_range_error
);
    import fdec_pkg::*;

    localparam int FW  = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int LW  = ($clog2(BUFFER_BYTES + 1) > 4) ? $clog2(BUFFER_BYTES + 1) : 4;
    localparam int FDW = 4 * MAX_FRAC_DIGITS;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_INT    = 9'b000000010,
        S_ALIGN  = 9'b000000100,
        S_NORM   = 9'b000001000,
        S_FRAC   = 9'b000010000,
        S_ESIGN  = 9'b000100000,
        S_EINT   = 9'b001000000,
        S_EDOT   = 9'b010000000,
        S_EFRAC  = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [MANT_W-1:0]   r_m, n_m;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [NDIG_W-1:0]   r_ndig, n_ndig;
    logic                r_neg, n_neg;
    logic                r_fzero, n_fzero;
    logic [FW-1:0]       r_gen, n_gen;
    logic [FW-1:0]       r_k, n_k;
    logic [FW-1:0]       r_lastnz, n_lastnz;
    logic [FW-1:0]       r_nde, n_nde;
    logic [FDW-1:0]      r_fd, n_fd;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_char, n_out_char;
    logic                r_out_last, n_out_last;
    logic                r_out_range, n_out_range;

    t_bcd_ctl            w_bcd_ctl;
    logic [3:0]          w_top;
    logic [7:0]          w_exp;
    logic [MANT_W+3:0]   w_f10;
    logic [3:0]          w_fdig;
    logic                w_fvalid;
    logic [LW-1:0]       w_blen;
    logic [LW-1:0]       w_room;

    fdec_bcd u_bcd (
        .i_clk       (i_clk),
        .i_ctl       (w_bcd_ctl),
        .o_top_digit (w_top)
    );

    assign w_exp = i_float_bits[30:23];

    // Times ten on the binary fraction; the carry-out is the next digit.
    assign w_f10    = {1'b0, r_m, 3'b000} + {3'b000, r_m, 1'b0};
    assign w_fvalid = (r_k < r_gen);
    assign w_fdig   = w_fvalid ? w_f10[MANT_W+3 -: 4] : 4'd0;

    // Characters ahead of the fraction digits: sign, integer digits, dot.
    assign w_blen = LW'(r_neg) + LW'(r_ndig) + LW'(1);
    assign w_room = (LW'(BUFFER_BYTES - 1) > w_blen) ? (LW'(BUFFER_BYTES - 1) - w_blen) : '0;

    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_cnt       = r_cnt;
        n_ndig      = r_ndig;
        n_neg       = r_neg;
        n_fzero     = r_fzero;
        n_gen       = r_gen;
        n_k         = r_k;
        n_lastnz    = r_lastnz;
        n_nde       = r_nde;
        n_fd        = r_fd;
        n_out_valid = 1'b0;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_range = r_out_range;
        w_bcd_ctl   = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (w_exp >= EXP_RANGE) begin
                        n_out_valid = 1'b1;
                        n_out_char  = CHAR_NUL;
                        n_out_last  = 1'b1;
                        n_out_range = 1'b1;
                    end else begin
                        w_bcd_ctl.clear = 1'b1;
                        // Signed zero prints without its sign.
                        n_neg  = i_float_bits[31] && (i_float_bits[30:0] != 31'd0);
                        n_ndig = NDIG_W'(INT_DIGITS);
                        n_m    = {1'b1, i_float_bits[22:0]};
                        if (w_exp >= EXP_BIAS) begin
                            n_cnt   = CNT_W'(w_exp - EXP_HALF);
                            n_state = S_INT;
                        end else if (w_exp >= EXP_FRAC_MIN) begin
                            n_cnt   = CNT_W'(EXP_HALF - w_exp);
                            n_state = S_ALIGN;
                        end else begin
                            n_m     = '0;
                            n_state = S_NORM;
                        end
                    end
                end
            end
            S_INT: begin
                // Integer bits leave the top of the significand into BCD;
                // what remains, zero filled, is the binary fraction.
                w_bcd_ctl.shift_bit = 1'b1;
                w_bcd_ctl.din       = r_m[MANT_W-1];
                n_m   = {r_m[MANT_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_NORM;
                end
            end
            S_ALIGN: begin
                if (r_cnt == '0) begin
                    n_state = S_NORM;
                end else begin
                    n_m   = {1'b0, r_m[MANT_W-1:1]};
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_NORM: begin
                if ((w_top == 4'd0) && (r_ndig > NDIG_W'(1))) begin
                    w_bcd_ctl.shift_digit = 1'b1;
                    n_ndig = r_ndig - NDIG_W'(1);
                end else begin
                    n_fzero  = (r_m == '0);
                    if ((r_m == '0) || (w_room == '0)) begin
                        n_gen = '0;
                    end else if (w_room > LW'(MAX_FRAC_DIGITS)) begin
                        n_gen = FW'(MAX_FRAC_DIGITS);
                    end else begin
                        n_gen = w_room[FW-1:0];
                    end
                    n_k      = '0;
                    n_lastnz = '0;
                    n_fd     = '0;
                    n_state  = S_FRAC;
                end
            end
            S_FRAC: begin
                // Runs the full digit count so the first digit ends up on top.
                if (w_fvalid) begin
                    n_m = w_f10[MANT_W-1:0];
                end
                if (w_fdig != 4'd0) begin
                    n_lastnz = r_k + FW'(1);
                end
                if (FDW > 4) begin
                    n_fd = {r_fd[FDW-5:0], w_fdig};
                end else begin
                    n_fd = FDW'(w_fdig);
                end
                n_k = r_k + FW'(1);
                if (r_k == FW'(MAX_FRAC_DIGITS - 1)) begin
                    // Trailing zeros go; one digit stays unless no fraction digit fits the buffer.
                    if (r_fzero) begin
                        n_nde = FW'(1);
                    end else if (r_gen == '0) begin
                        n_nde = '0;
                    end else if (n_lastnz == '0) begin
                        n_nde = FW'(1);
                    end else begin
                        n_nde = n_lastnz;
                    end
                    n_cnt   = CNT_W'(r_ndig) - CNT_W'(1);
                    n_state = r_neg ? S_ESIGN : S_EINT;
                end
            end
            S_ESIGN: begin
                n_out_valid = 1'b1;
                n_out_char  = CHAR_MINUS;
                n_out_last  = 1'b0;
                n_out_range = 1'b0;
                n_state     = S_EINT;
            end
            S_EINT: begin
                w_bcd_ctl.shift_digit = 1'b1;
                n_out_valid = 1'b1;
                n_out_char  = CHAR_ZERO + {4'd0, w_top};
                n_out_last  = 1'b0;
                n_out_range = 1'b0;
                n_cnt       = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_EDOT;
                end
            end
            S_EDOT: begin
                n_out_valid = 1'b1;
                n_out_char  = CHAR_DOT;
                n_out_last  = (r_nde == '0);
                n_out_range = 1'b0;
                n_state     = (r_nde == '0) ? S_IDLE : S_EFRAC;
            end
            S_EFRAC: begin
                n_out_valid = 1'b1;
                n_out_char  = CHAR_ZERO + {4'd0, r_fd[FDW-1 -: 4]};
                n_out_last  = (r_nde == FW'(1));
                n_out_range = 1'b0;
                if (FDW > 4) begin
                    n_fd = {r_fd[FDW-5:0], 4'b0000};
                end else begin
                    n_fd = '0;
                end
                n_nde = r_nde - FW'(1);
                if (r_nde == FW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m         <= n_m;
        r_cnt       <= n_cnt;
        r_ndig      <= n_ndig;
        r_neg       <= n_neg;
        r_fzero     <= n_fzero;
        r_gen       <= n_gen;
        r_k         <= n_k;
        r_lastnz    <= n_lastnz;
        r_nde       <= n_nde;
        r_fd        <= n_fd;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_out_range <= n_out_range;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_last_char   = r_out_last;
    assign o_range_error = r_out_range;

endmodule

/* src/fdec_checker.sv */
// Port-level checks on the converter, bound to its top level.
module fdec_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic [31:0] i_float_bits,
    input logic        busy,
    input logic        o_valid,
    input logic [7:0]  o_out_char,
    input logic        o_last_char,
    input logic        o_range_error
);

    // A range word is a lone NUL character that closes its text.
    a_range_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_last_char && (o_out_char == 8'h00))
        else $error("range word is not a closing NUL");

    // The last word of a text comes exactly when the block has gone idle.
    a_last_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_char == !busy))
        else $error("last-character flag disagrees with busy");

    // An accepted word either starts a conversion or answers at once with a range word.
    a_start_takes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || (o_valid && o_range_error))
        else $error("accepted word produced neither work nor a range word");

    // Text holds only digits, a dot or a minus sign.
    a_char_set : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_range_error |->
            ((o_out_char >= 8'h30) && (o_out_char <= 8'h39)) ||
            (o_out_char == 8'h2E) || (o_out_char == 8'h2D))
        else $error("character outside the decimal text set");

endmodule

bind float_to_decimal_ascii fdec_checker u_fdec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .i_float_bits  (i_float_bits),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_out_char    (o_out_char),
    .o_last_char   (o_last_char),
    .o_range_error (o_range_error)
);

/* tb/sv/fdec_text_checker.sv */
// Checker for the float to decimal text converter: predicts each word's characters and compares.
`timescale 1ns / 1ps

module fdec_text_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_float_bits,
    input  logic        i_valid,
    input  logic [7:0]  i_out_char,
    input  logic        i_last_char,
    input  logic        i_range_error,
    output int          o_mismatches,
    output int          o_pending
);
    import fdec_pkg::*;

    localparam int MANT_BITS = MANT_W - 1;

    typedef struct packed {
        logic [31:0] src_word;
        logic [7:0]  ch;
        logic        last;
        logic        rerr;
    } t_text_char;

    t_text_char expected_chars[$];
    t_text_char want;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(string field, logic [31:0] word, logic [7:0] got,
                                   logic [7:0] exp_val);
        $display("%0t ns: word %h: %s got %h, predicted %h",
                 $realtime, word, field, got, exp_val);
        o_mismatches++;
    endtask

    // Appends the characters that one accepted word must produce.
    function automatic void predict_text(logic [31:0] bits);
        logic [7:0]  txt[$];
        logic [7:0]  int_digits[$];
        logic [23:0] mant;
        logic [23:0] frac;
        logic [27:0] scaled;
        logic [31:0] ipart;
        int          e;
        int          sh;
        int          max_digits;
        t_text_char  c;
        ipart = '0;
        frac  = '0;
        if (bits[30:0] == '0) begin
            txt = '{CHAR_ZERO, CHAR_DOT, CHAR_ZERO};
        end else begin
            e = int'(bits[30:23]) - int'(EXP_BIAS);
            if (e >= 31) begin
                c.src_word = bits;
                c.ch       = CHAR_NUL;
                c.last     = 1'b1;
                c.rerr     = 1'b1;
                expected_chars.push_back(c);
                return;
            end
            mant = {1'b1, bits[22:0]};
            if (e >= MANT_BITS) begin
                ipart = 32'(mant) << (e - MANT_BITS);
            end else if (e >= 0) begin
                ipart = 32'(mant >> (MANT_BITS - e));
                frac  = mant << (e + 1);
            end else begin
                sh   = -(e + 1);
                frac = (sh < MANT_W) ? (mant >> sh) : '0;
            end
            if (bits[31])
                txt.push_back(CHAR_MINUS);
            if (ipart == '0) begin
                txt.push_back(CHAR_ZERO);
            end else begin
                while (ipart != '0) begin
                    int_digits.push_front(8'(CHAR_ZERO + ipart % 10));
                    ipart = ipart / 10;
                end
                foreach (int_digits[k])
                    txt.push_back(int_digits[k]);
            end
            txt.push_back(CHAR_DOT);
            if (frac == '0) begin
                txt.push_back(CHAR_ZERO);
            end else begin
                max_digits = BUFFER_BYTES_DEF - txt.size() - 1;
                if (max_digits > MAX_FRAC_DIGITS_DEF)
                    max_digits = MAX_FRAC_DIGITS_DEF;
                // Digits are truncated: each step multiplies by ten and takes the carry-out.
                for (int m = 0; m < max_digits; m++) begin
                    scaled = 28'(frac) * 28'd10;
                    txt.push_back(8'(CHAR_ZERO + scaled[27:24]));
                    frac = scaled[23:0];
                end
                while (txt.size() >= 2 && txt[txt.size() - 1] == CHAR_ZERO
                       && txt[txt.size() - 2] != CHAR_DOT)
                    void'(txt.pop_back());
            end
        end
        foreach (txt[k]) begin
            c.src_word = bits;
            c.ch       = txt[k];
            c.last     = (k == txt.size() - 1);
            c.rerr     = 1'b0;
            expected_chars.push_back(c);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Characters of an older word are checked before the new word's prediction is queued.
            if (i_valid) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected character", '0, i_out_char, CHAR_NUL);
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_char !== want.ch)
                        report_mismatch("out_char", want.src_word, i_out_char, want.ch);
                    if (i_last_char !== want.last)
                        report_mismatch("last_char", want.src_word, 8'(i_last_char),
                                        8'(want.last));
                    if (i_range_error !== want.rerr)
                        report_mismatch("range_error", want.src_word, 8'(i_range_error),
                                        8'(want.rerr));
                end
            end
            if (i_start && !i_busy)
                predict_text(i_float_bits);
        end
        o_pending = expected_chars.size();
    end

endmodule

/* tb/sv/tb_float_to_decimal_ascii.sv */
// Testbench top for the float to decimal text converter: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_float_to_decimal_ascii;

    localparam int RANDOM_WORDS = 205;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 70;

    localparam logic [31:0] CORNER_WORDS [25] = '{
        32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000,
        32'h3380_0000, 32'h3300_0000, 32'h3F00_0000, 32'h3F7F_FFFF, 32'h3F80_0000,
        32'hBF80_0000, 32'h3DCC_CCCD, 32'h4049_0FDB, 32'h42F6_E979, 32'h3F80_0001,
        32'h4AFF_FFFF, 32'hCAFF_FFFF, 32'h4B00_0000, 32'h4B7F_FFFF, 32'h4EFF_FFFF,
        32'hCEFF_FFFF, 32'h4F00_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic [31:0] i_float_bits;
    logic        busy;
    logic        o_valid;
    logic [7:0]  o_out_char;
    logic        o_last_char;
    logic        o_range_error;
    int          mismatch_count;
    int          chars_pending;
    int          idle_cycles;

    float_to_decimal_ascii DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_float_bits  (i_float_bits),
        .busy          (busy),
        .o_valid       (o_valid),
        .o_out_char    (o_out_char),
        .o_last_char   (o_last_char),
        .o_range_error (o_range_error)
    );

    fdec_text_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_float_bits  (i_float_bits),
        .i_valid       (o_valid),
        .i_out_char    (o_out_char),
        .i_last_char   (o_last_char),
        .i_range_error (o_range_error),
        .o_mismatches  (mismatch_count),
        .o_pending     (chars_pending)
    );

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_float_bits = '0;
        idle_cycles  = 0;
    end

    always #10 i_clk = ~i_clk;

    // Ends the run when neither a word goes in nor a character comes out for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Holds start high until the block takes the word; leaves time at the next falling edge.
    task automatic send_word(logic [31:0] w, int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        = 1'b1;
        i_float_bits = w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Most words land in the convertible range so that integer and fraction digits both show up.
    function automatic logic [31:0] draw_word();
        int          pick;
        logic [7:0]  biased;
        logic [22:0] mant;
        pick = $urandom_range(0, 99);
        mant = 23'($urandom());
        if (pick < 25)
            return $urandom();
        if (pick < 70) begin
            biased = 8'($urandom_range(103, 157));
        end else if (pick < 82) begin
            biased = 8'($urandom_range(118, 150));
            mant   = mant & ~23'((1 << $urandom_range(0, 23)) - 1);
        end else if (pick < 91) begin
            biased = 8'($urandom_range(158, 255));
        end else begin
            biased = 8'($urandom_range(0, 102));
            if ($urandom_range(0, 2) == 0)
                mant = '0;
        end
        return {1'($urandom()), biased, mant};
    endfunction

    initial begin
        int gap;
        bit no_gaps;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (CORNER_WORDS[k])
            send_word(CORNER_WORDS[k], $urandom_range(0, 9));

        no_gaps = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 16 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_WORDS / 2) begin
                start = 1'b0;
                while (chars_pending != 0) @(negedge i_clk);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 9);
            send_word(draw_word(), gap);
        end
        start = 1'b0;

        while (chars_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && chars_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
src/fdec_pkg.sv
src/fdec_bcd.sv
src/float_to_decimal_ascii.sv
src/fdec_checker.sv
tb/sv/fdec_text_checker.sv
tb/sv/tb_float_to_decimal_ascii.sv
